### rtl/olrb_pkg.sv
// olrb_pkg: shared constants, command codes and stage types of the overwriting log ring buffer
// no dependencies; used by olrb_ctrl and overwriting_log_ring_buffer_top
`default_nettype none

package olrb_pkg;

    localparam int RING_DEPTH = 16384;
    localparam int AW         = $clog2(RING_DEPTH);
    localparam int CW         = AW + 1;
    localparam int DATA_W     = 8;
    localparam int WIN_W      = 15;
    localparam int OFS_W      = 14;
    localparam int DROP_W     = 32;
    localparam int MW         = (CW > WIN_W) ? CW : WIN_W;
    localparam int IN_TDATA_W = 40;
    localparam int OUT_TDATA_W = 72;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    typedef struct packed {
        logic              read_valid;
        logic [WIN_W-1:0]  window_length;
        logic [WIN_W-1:0]  used_count;
        logic [DROP_W-1:0] dropped_count;
    } t_meta;

    typedef struct packed {
        logic [DATA_W-1:0] read_byte;
        t_meta             meta;
    } t_res;

endpackage

`default_nettype wire

### rtl/olrb_ram.sv
// olrb_ram: generic single-clock ram, one write port and one read port with registered read
// no dependencies
`default_nettype none

module olrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wen,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_ren,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ren) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/olrb_ctrl.sv
// olrb_ctrl: head, held count and dropped counter, ram address generation and result pipeline
// depends on olrb_pkg; drives the ports of olrb_ram
`default_nettype none

module olrb_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [1:0]                   i_cmd,
    input  wire logic [olrb_pkg::DATA_W-1:0]  i_data_byte,
    input  wire logic [olrb_pkg::WIN_W-1:0]   i_window,
    input  wire logic [olrb_pkg::OFS_W-1:0]   i_offset,
    output logic                              o_wen,
    output logic      [olrb_pkg::AW-1:0]      o_waddr,
    output logic      [olrb_pkg::DATA_W-1:0]  o_wdata,
    output logic                              o_ren,
    output logic      [olrb_pkg::AW-1:0]      o_raddr,
    input  wire logic [olrb_pkg::DATA_W-1:0]  i_rdata,
    output logic                              o_res_valid,
    input  wire logic                         i_res_ready,
    output olrb_pkg::t_res                    o_res
);

    logic [olrb_pkg::AW-1:0]     r_wp, n_wp;
    logic [olrb_pkg::CW-1:0]     r_held, n_held;
    logic [olrb_pkg::DROP_W-1:0] r_drop, n_drop;
    logic                        r_s1_valid;
    olrb_pkg::t_meta             r_s1, n_s1;
    logic                        r_out_valid;
    olrb_pkg::t_res              r_out;

    logic                        in_fire;
    logic                        s1_adv;
    logic [olrb_pkg::MW-1:0]     win_ext;
    logic [olrb_pkg::MW-1:0]     held_ext;
    logic [olrb_pkg::MW-1:0]     wlen_ext;
    logic [olrb_pkg::WIN_W-1:0]  wlen;
    logic                        hit;

    assign s1_adv  = r_s1_valid & (~r_out_valid | i_res_ready);
    assign o_ready = ~r_s1_valid | s1_adv;
    assign in_fire = i_valid & o_ready;

    assign win_ext  = olrb_pkg::MW'(i_window);
    assign held_ext = olrb_pkg::MW'(r_held);
    assign wlen_ext = (win_ext < held_ext) ? win_ext : held_ext;
    assign wlen     = olrb_pkg::WIN_W'(wlen_ext);
    assign hit      = olrb_pkg::MW'(i_offset) < wlen_ext;

    assign o_wdata = i_data_byte;
    assign o_waddr = r_wp;
    assign o_raddr = olrb_pkg::AW'(r_wp + olrb_pkg::AW'(i_offset) - olrb_pkg::AW'(wlen_ext));

    always_comb begin
        n_wp   = r_wp;
        n_held = r_held;
        n_drop = r_drop;
        o_wen  = 1'b0;
        o_ren  = 1'b0;
        n_s1.read_valid    = 1'b0;
        n_s1.window_length = '0;
        unique case (i_cmd)
            olrb_pkg::CMD_APPEND: begin
                o_wen = in_fire;
                n_wp  = olrb_pkg::AW'(r_wp + 1'b1);
                if (r_held >= olrb_pkg::CW'(olrb_pkg::RING_DEPTH)) begin
                    n_drop = r_drop + 1'b1;
                end else begin
                    n_held = r_held + 1'b1;
                end
            end
            olrb_pkg::CMD_READ: begin
                n_s1.window_length = wlen;
                n_s1.read_valid    = hit;
                o_ren              = in_fire & hit;
            end
            olrb_pkg::CMD_CLEAR: begin
                n_wp   = '0;
                n_held = '0;
                n_drop = '0;
            end
            default: begin
            end
        endcase
        n_s1.used_count    = olrb_pkg::WIN_W'(n_held);
        n_s1.dropped_count = n_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_held      <= '0;
            r_drop      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_wp   <= n_wp;
                r_held <= n_held;
                r_drop <= n_drop;
            end
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            r_out.meta      <= r_s1;
            r_out.read_byte <= r_s1.read_valid ? i_rdata : '0;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

`default_nettype wire

### rtl/overwriting_log_ring_buffer_top.sv
// overwriting_log_ring_buffer_top: top level of the overwriting byte ring
// depends on olrb_pkg, olrb_ram and olrb_ctrl
//
// usage
//   slave stream s_axis: one command beat per item, tuser carries the command
//   (append, read, clear), tdata the byte, the read window and the read offset.
//   master stream m_axis: exactly one result beat per command beat, in order.
//   appends write the byte at the head; on a full ring the oldest byte is
//   overwritten and the dropped counter (32 bits, wrapping) counts it.
//   reads return the byte at an offset in the newest min(window, held) bytes.
//   timing: a beat is taken every cycle when the output side keeps up; the
//   result passes the ram read (a single port pair of one byte ram) and then
//   the output register before it appears on m_axis.
//   a stalled master side backs up into s_axis_tready after two results queue.
//   reset (synchronous, active low) empties the ring and zeroes the counters;
//   the ram content is not cleared, bytes become reachable only once written.
`default_nettype none

module overwriting_log_ring_buffer_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // data_byte[7:0], window[22:8], offset[36:23], zero fill
    input  wire logic [olrb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // cmd[1:0]
    input  wire logic [1:0]                        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // read_byte[7:0], window_length[22:8], used_count[37:23], dropped_count[69:38], zero fill
    output logic      [olrb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // read_valid[0]
    output logic                                   m_axis_tuser
);

    logic                        wen;
    logic [olrb_pkg::AW-1:0]     waddr;
    logic [olrb_pkg::DATA_W-1:0] wdata;
    logic                        ren;
    logic [olrb_pkg::AW-1:0]     raddr;
    logic [olrb_pkg::DATA_W-1:0] rdata;
    olrb_pkg::t_res              res;

    olrb_ram #(
        .WIDTH (olrb_pkg::DATA_W),
        .DEPTH (olrb_pkg::RING_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_wen   (wen),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_ren   (ren),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    olrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_cmd       (s_axis_tuser),
        .i_data_byte (s_axis_tdata[7:0]),
        .i_window    (s_axis_tdata[22:8]),
        .i_offset    (s_axis_tdata[36:23]),
        .o_wen       (wen),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_ren       (ren),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    assign m_axis_tdata = {2'b00, res.meta.dropped_count, res.meta.used_count,
                           res.meta.window_length, res.read_byte};
    assign m_axis_tuser = res.meta.read_valid;

endmodule

`default_nettype wire
